[hdl/hcbp_pkg.sv]
// Package with the action codes, field widths and result type of the Huffman code bit packer.
package hcbp_pkg;

    // Action codes carried in the input tuser field.
    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_ENC   = 2'd1;
    localparam logic [1:0] ACT_FLUSH = 2'd2;

    // Field widths fixed by the stream format.
    localparam int unsigned CODE_W  = 16;
    localparam int unsigned LEN_W   = 5;
    localparam int unsigned PEND_W  = 7;
    localparam int unsigned CNT_W   = 3;
    localparam int unsigned ACC_W   = CODE_W + PEND_W;

    // Depth of the result queue and its pointer and fill widths.
    localparam int unsigned RQ_DEPTH = 4;
    localparam int unsigned RQ_PTR_W = 2;
    localparam int unsigned RQ_CNT_W = 3;

    // One result item waiting for the output port.
    typedef struct packed {
        logic       last;
        logic [2:0] pad;
        logic [7:0] data;
    } t_res;

endpackage

[hdl/huffman_code_bit_packer.sv]
// Huffman code bit packer: code table memory, bit accumulator and output result queue.
// The table read of an accepted item is registered in stage one; its results then go through the result queue.
// Throughput: one item per cycle while the four-entry result queue has room for two results;
// the output port moves one byte per cycle while i_m_tready is high, so a symbol that yields two bytes uses it twice.
// Reset (i_rst_n, synchronous, active low) clears the table valid bits, the pending bits and
// the queue; code storage itself is not cleared and reads as unused until loaded.
module huffman_code_bit_packer
    import hcbp_pkg::*;
#(
    parameter int unsigned MAX_CODE_LEN = 16,
    parameter int unsigned SYMBOL_COUNT = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input item stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // symbol[7:0], code_value[23:8], code_length[28:24]
    input  logic [1:0]  i_s_tuser,   // action[1:0]
    // Result item stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // packed_byte[7:0], pad_bits[10:8]
    output logic        o_m_tlast    // last_of_run
);

    localparam int unsigned AW      = $clog2(SYMBOL_COUNT);
    localparam int unsigned LEN_LIM = (MAX_CODE_LEN > 16) ? 16 : MAX_CODE_LEN;

    // Input field split.
    logic [1:0]        in_action;
    logic [7:0]        in_symbol;
    logic [CODE_W-1:0] in_code;
    logic [LEN_W-1:0]  in_len;
    logic [LEN_W-1:0]  sat_len;
    logic [AW-1:0]     addr;
    logic              in_range;
    logic              in_fire;

    assign in_action = i_s_tuser;
    assign in_symbol = i_s_tdata[7:0];
    assign in_code   = i_s_tdata[23:8];
    assign in_len    = i_s_tdata[28:24];
    assign sat_len   = (in_len > LEN_W'(LEN_LIM)) ? LEN_W'(LEN_LIM) : in_len;
    assign addr      = in_symbol[AW-1:0];
    assign in_range  = ({1'b0, in_symbol} < 9'(SYMBOL_COUNT));

    // Code table memory and valid bits.
    logic [CODE_W-1:0]       mem_code [SYMBOL_COUNT];
    logic [LEN_W-1:0]        mem_len  [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] r_tbl_vld;
    logic [CODE_W-1:0]       r_rd_code;
    logic [LEN_W-1:0]        r_rd_len;
    logic                    r_rd_vld;

    // Stage one control and pending bits.
    logic              r_s1_valid;
    logic [1:0]        r_s1_action;
    logic [PEND_W-1:0] r_pend_bits;
    logic [CNT_W-1:0]  r_pend_cnt;
    logic              s1_fire;

    // Result queue.
    t_res                r_rq [RQ_DEPTH];
    logic [RQ_PTR_W-1:0] r_wr_ptr;
    logic [RQ_PTR_W-1:0] r_rd_ptr;
    logic [RQ_CNT_W-1:0] r_rq_cnt;
    logic                pop;

    assign s1_fire    = r_s1_valid && (r_rq_cnt <= RQ_CNT_W'(RQ_DEPTH - 2));
    assign o_s_tready = !r_s1_valid || s1_fire;
    assign in_fire    = i_s_tvalid && o_s_tready;

    // Table write on load and registered table read on every accepted item.
    always_ff @(posedge i_clk) begin
        if (in_fire && (in_action == ACT_LOAD) && in_range) begin
            mem_code[addr] <= in_code;
            mem_len[addr]  <= sat_len;
        end
        if (in_fire) begin
            r_rd_code <= mem_code[addr];
            r_rd_len  <= mem_len[addr];
        end
    end

    // Valid bits mark loaded entries; an entry that is not valid has length zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tbl_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else if (in_fire) begin
            if ((in_action == ACT_LOAD) && in_range) begin
                r_tbl_vld[addr] <= 1'b1;
            end
            r_rd_vld <= r_tbl_vld[addr] && in_range;
        end
    end

    // Stage one holds the action of the item whose table read is in flight.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= in_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_action <= in_action;
        end
    end

    // Bit accumulator: append the masked code below the pending bits.
    logic [LEN_W-1:0]  eff_len;
    logic [CODE_W:0]   code_mask;
    logic [CODE_W-1:0] code_m;
    logic [ACC_W-1:0]  acc;
    logic [LEN_W-1:0]  tot;
    logic [1:0]        nbytes;
    logic [CNT_W-1:0]  rem;
    logic [LEN_W-1:0]  sh0;
    logic [LEN_W-1:0]  sh1;
    logic [7:0]        byte0;
    logic [7:0]        byte1;
    logic [7:0]        rem_mask;
    logic [PEND_W-1:0] enc_pend;
    logic [CNT_W-1:0]  fl_pad;
    logic [7:0]        fl_byte;

    assign eff_len   = r_rd_vld ? r_rd_len : '0;
    assign code_mask = ((CODE_W+1)'(1) << eff_len) - (CODE_W+1)'(1);
    assign code_m    = r_rd_code & code_mask[CODE_W-1:0];
    assign acc       = ({{CODE_W{1'b0}}, r_pend_bits} << eff_len) | {{PEND_W{1'b0}}, code_m};
    assign tot       = {2'b00, r_pend_cnt} + eff_len;
    assign nbytes    = tot[4:3];
    assign rem       = tot[2:0];
    assign sh0       = tot - LEN_W'(8);
    assign sh1       = tot - LEN_W'(16);
    assign byte0     = 8'(acc >> sh0);
    assign byte1     = 8'(acc >> sh1);
    assign rem_mask  = (8'd1 << rem) - 8'd1;
    assign enc_pend  = acc[PEND_W-1:0] & rem_mask[PEND_W-1:0];
    assign fl_pad    = 3'(4'd8 - {1'b0, r_pend_cnt});
    assign fl_byte   = 8'({1'b0, r_pend_bits} << fl_pad);

    // Results pushed into the queue by stage one.
    logic [1:0] push_n;
    t_res       res0;
    t_res       res1;

    always_comb begin
        push_n = 2'd0;
        res0   = '{last: 1'b1, pad: 3'd0, data: byte0};
        res1   = '{last: 1'b1, pad: 3'd0, data: byte1};
        if (s1_fire) begin
            case (r_s1_action)
                ACT_ENC: begin
                    push_n    = nbytes;
                    res0.last = (nbytes == 2'd1);
                end
                ACT_FLUSH: begin
                    if (r_pend_cnt != '0) begin
                        push_n = 2'd1;
                        res0   = '{last: 1'b1, pad: fl_pad, data: fl_byte};
                    end
                end
                default: begin
                    push_n = 2'd0;
                end
            endcase
        end
    end

    // Pending bits update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
        end else if (s1_fire) begin
            if (r_s1_action == ACT_ENC) begin
                r_pend_bits <= enc_pend;
                r_pend_cnt  <= rem;
            end else if (r_s1_action == ACT_FLUSH) begin
                r_pend_bits <= '0;
                r_pend_cnt  <= '0;
            end
        end
    end

    // Result queue storage.
    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_rq[r_wr_ptr] <= res0;
        end
        if (push_n == 2'd2) begin
            r_rq[r_wr_ptr + RQ_PTR_W'(1)] <= res1;
        end
    end

    // Result queue pointers and fill count.
    assign pop = o_m_tvalid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_rq_cnt <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + RQ_PTR_W'(push_n);
            r_rd_ptr <= r_rd_ptr + RQ_PTR_W'(pop);
            r_rq_cnt <= r_rq_cnt + RQ_CNT_W'(push_n) - RQ_CNT_W'(pop);
        end
    end

    // Output port driven from the queue head.
    t_res head;

    assign head       = r_rq[r_rd_ptr];
    assign o_m_tvalid = (r_rq_cnt != '0);
    assign o_m_tdata  = {5'd0, head.pad, head.data};
    assign o_m_tlast  = head.last;

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the Huffman code bit packer, with a predictor and a result scoreboard.
`timescale 1ns / 1ps

module tb_top
    import hcbp_pkg::*;
();

    // Action code that the block ignores.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Longest code that the table stores.
    localparam int unsigned CODE_LEN_CAP = 16;

    // Cycles without any accepted item before the run is declared hung.
    localparam int unsigned STALL_LIMIT = 4000;

    // Cycles allowed after the last result for stray output to show up.
    localparam int unsigned DRAIN_CYCLES = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata = '0;    // symbol[7:0], code_value[23:8], code_length[28:24]
    logic [1:0]  i_s_tuser = '0;    // action[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;         // packed_byte[7:0], pad_bits[10:8]
    logic        o_m_tlast;

    huffman_code_bit_packer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // Predictor state: its own copy of the code table and the bit accumulator.
    logic [15:0] code_bits_mem [256];
    logic [4:0]  code_len_mem [256];
    logic [6:0]  acc_bits;
    int unsigned acc_count;

    t_res        expected_bytes [$];
    logic [7:0]  loaded_symbols [$];
    int unsigned error_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_off_cycles = 0;

    // Free-running clock.
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Records a failure and prints the first ten of them.
    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= 10) begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
    endtask

    // Works out the result bytes that one accepted item causes and queues them.
    task automatic predict_packed_bytes(input logic [1:0] act, input logic [7:0] sym,
                                        input logic [15:0] cval, input logic [4:0] clen);
        t_res        res [3];
        int unsigned n_res;
        logic [7:0]  acc;
        int unsigned cnt;
        int unsigned len;
        int unsigned pad;
        n_res = 0;
        case (act)
            ACT_LOAD: begin
                // Lengths beyond the code width saturate.
                code_bits_mem[sym] = cval;
                code_len_mem[sym]  = (clen > CODE_LEN_CAP) ? 5'(CODE_LEN_CAP) : clen;
            end
            ACT_ENC: begin
                // Shift the code in first bit first and emit every full byte.
                acc = {1'b0, acc_bits};
                cnt = acc_count;
                len = code_len_mem[sym];
                for (int i = len; i > 0; i--) begin
                    acc = {acc[6:0], code_bits_mem[sym][i-1]};
                    cnt++;
                    if (cnt == 8) begin
                        res[n_res] = '{last: 1'b0, pad: 3'd0, data: acc};
                        n_res++;
                        acc = '0;
                        cnt = 0;
                    end
                end
                acc_bits  = acc[6:0];
                acc_count = cnt;
            end
            ACT_FLUSH: begin
                // Pad the partial byte with zeros; nothing happens when it is empty.
                if (acc_count != 0) begin
                    pad = 8 - acc_count;
                    res[0] = '{last: 1'b0, pad: 3'(pad), data: 8'({1'b0, acc_bits} << pad)};
                    n_res = 1;
                    acc_bits  = '0;
                    acc_count = 0;
                end
            end
            default: ;
        endcase
        if (n_res > 0) begin
            res[n_res-1].last = 1'b1;
        end
        for (int k = 0; k < n_res; k++) begin
            expected_bytes.push_back(res[k]);
        end
    endtask

    // Offers one item, with random idle cycles in front, and predicts it once accepted.
    task automatic send_item(input logic [1:0] act, input logic [7:0] sym,
                             input logic [15:0] cval, input logic [4:0] clen);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {3'b000, clen, cval, sym};
        i_s_tuser  <= act;
        do begin
            @(posedge i_clk);
        end while (!o_s_tready);
        predict_packed_bytes(act, sym, cval, clen);
    endtask

    // Stops offering items and waits until every expected byte has arrived.
    task automatic wait_drained();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                hold_off_cycles--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Result checker: each accepted byte against the oldest expectation.
    initial begin
        t_res want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                if (expected_bytes.size() == 0) begin
                    report_error($sformatf("unexpected result data=%h pad=%0d last=%b",
                                           o_m_tdata[7:0], o_m_tdata[10:8], o_m_tlast));
                end else begin
                    want = expected_bytes.pop_front();
                    if (o_m_tdata[7:0] !== want.data || o_m_tdata[10:8] !== want.pad ||
                        o_m_tlast !== want.last) begin
                        report_error($sformatf(
                            "expected data=%h pad=%0d last=%b, got data=%h pad=%0d last=%b",
                            want.data, want.pad, want.last,
                            o_m_tdata[7:0], o_m_tdata[10:8], o_m_tlast));
                    end
                end
            end
        end
    end

    // Watchdog on cycles in which neither side accepts an item.
    initial begin
        int unsigned quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Table extremes, every action and the corner cases of the packer.
    task automatic test_directed();
        send_idle_pct = 29;
        recv_idle_pct = 56;
        send_item(ACT_ENC,   8'h00, 16'h0000, 5'd0);     // unloaded symbol emits nothing
        send_item(ACT_FLUSH, 8'h00, 16'h0000, 5'd0);     // flush with nothing pending
        send_item(ACT_LOAD,  8'h00, 16'hFFFF, 5'd16);
        send_item(ACT_LOAD,  8'hFF, 16'h0000, 5'd16);
        send_item(ACT_LOAD,  8'h01, 16'h0001, 5'd1);
        send_item(ACT_LOAD,  8'h02, 16'hA5C3, 5'd31);    // overlong length saturates
        send_item(ACT_LOAD,  8'h03, 16'hFFFF, 5'd0);     // zero length, so the symbol emits nothing
        send_item(ACT_LOAD,  8'h04, 16'hFF55, 5'd7);     // only the low bits are used
        send_item(ACT_LOAD,  8'h05, 16'h5A5A, 5'd17);
        send_item(ACT_ENC,   8'h00, 16'hFFFF, 5'd31);
        send_item(ACT_ENC,   8'hFF, 16'h0000, 5'd0);
        send_item(ACT_ENC,   8'h01, 16'h0000, 5'd0);
        send_item(ACT_ENC,   8'h00, 16'h0000, 5'd0);
        send_item(ACT_ENC,   8'h04, 16'h0000, 5'd0);
        send_item(ACT_ENC,   8'h01, 16'h0000, 5'd0);
        send_item(ACT_FLUSH, 8'hFF, 16'hFFFF, 5'd31);    // seven pad bits
        send_item(ACT_ENC,   8'h02, 16'h0000, 5'd0);
        send_item(ACT_ENC,   8'h03, 16'h0000, 5'd0);
        send_item(ACT_UNUSED, 8'hFF, 16'hFFFF, 5'd31);   // ignored action
        send_item(ACT_ENC,   8'h04, 16'h0000, 5'd0);
        send_item(ACT_FLUSH, 8'h00, 16'h0000, 5'd0);     // one pad bit
        send_item(ACT_ENC,   8'h05, 16'h0000, 5'd0);
        send_item(ACT_ENC,   8'h01, 16'h0000, 5'd0);
        send_item(ACT_FLUSH, 8'h00, 16'h0000, 5'd0);
        wait_drained();
    endtask

    // Mostly loads and encodes of loaded symbols, with flushes and some noise.
    task automatic test_random_traffic(input int unsigned n_items, input int unsigned s_pct,
                                       input int unsigned r_pct);
        int unsigned done;
        int unsigned pick;
        logic [7:0]  sym;
        logic [4:0]  clen;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        done = 0;
        while (done < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                sym  = 8'($urandom);
                clen = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                   : 5'($urandom_range(1, 16));
                send_item(ACT_LOAD, sym, 16'($urandom), clen);
                loaded_symbols.push_back(sym);
                done++;
            end else if (pick < 85) begin
                if (loaded_symbols.size() != 0 && $urandom_range(0, 9) != 0) begin
                    sym = loaded_symbols[$urandom_range(0, loaded_symbols.size() - 1)];
                end else begin
                    sym = 8'($urandom);
                end
                send_item(ACT_ENC, sym, 16'($urandom), 5'($urandom));
                done++;
            end else if (pick < 97) begin
                send_item(ACT_FLUSH, 8'($urandom), 16'($urandom), 5'($urandom));
                done++;
            end else begin
                send_item(ACT_UNUSED, 8'($urandom), 16'($urandom), 5'($urandom));
            end
        end
        wait_drained();
    endtask

    // Long receiver hold-off while two-byte codes keep coming, so the input stalls.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_item(ACT_LOAD, 8'h80, 16'($urandom), 5'd16);
        send_item(ACT_LOAD, 8'h81, 16'($urandom), 5'd15);
        hold_off_cycles = 80;
        for (int k = 0; k < 30; k++) begin
            send_item(ACT_ENC, ($urandom_range(0, 1) != 0) ? 8'h80 : 8'h81,
                      16'($urandom), 5'($urandom));
        end
        send_item(ACT_FLUSH, 8'h00, 16'h0000, 5'd0);
        wait_drained();
    endtask

    // Reset once, then the tests in turn, then the verdict.
    initial begin
        acc_bits  = '0;
        acc_count = 0;
        for (int k = 0; k < 256; k++) begin
            code_len_mem[k]  = '0;
            code_bits_mem[k] = '0;
        end
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_traffic(135, 29, 56);
        test_backpressure();
        test_random_traffic(135, 56, 29);
        test_random_traffic(135, 0, 0);

        if (expected_bytes.size() != 0) begin
            report_error($sformatf("%0d expected results never arrived",
                                   expected_bytes.size()));
        end
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/hcbp_pkg.sv
hdl/huffman_code_bit_packer.sv
dv/tb_top.sv
